// ----- rtl/mcbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared constants, types and helpers for the multi-channel byte FIFO.
// ----------------------------------------------------------------------------
package mcbf_pkg;

  localparam int CHANNELS = 4;
  localparam int DEPTH    = 256;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int ADDR_W = $clog2(CHANNELS * DEPTH);
  localparam int CNT_W  = 16;

  typedef logic [1:0]        mode_field_t;
  typedef logic [2:0]        chan_field_t;
  typedef logic [7:0]        byte_t;
  typedef logic [CH_W-1:0]   ch_idx_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADCH = 2'd3
  } status_t;

  // Ring increment, wraps at DEPTH.
  function automatic ptr_t next_slot(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Channel base plus slot offset in the shared store.
  function automatic addr_t slot_addr(input ch_idx_t ch, input ptr_t p);
    addr_t r;
    r = ADDR_W'(ch) * ADDR_W'(DEPTH) + ADDR_W'(p);
    return r;
  endfunction

endpackage

// ----- rtl/mcbf_if.sv -----
// ----------------------------------------------------------------------------
// mcbf_if
// Valid/ready channels: command items in, result items out.
// ----------------------------------------------------------------------------
interface mcbf_cmd_if;
  logic                  valid;
  logic                  ready;
  mcbf_pkg::mode_field_t mode;
  mcbf_pkg::chan_field_t channel;
  mcbf_pkg::byte_t       data_in;
  logic                  last;

  modport source (output valid, mode, channel, data_in, last, input ready);
  modport sink   (input valid, mode, channel, data_in, last, output ready);
endinterface

interface mcbf_rsp_if;
  logic             valid;
  logic             ready;
  mcbf_pkg::byte_t  data_out;
  logic [1:0]       status;
  mcbf_pkg::count_t accepted_count;
  logic             now_empty;
  logic             now_full;

  modport source (output valid, data_out, status, accepted_count, now_empty, now_full,
                  input ready);
  modport sink   (input valid, data_out, status, accepted_count, now_empty, now_full,
                  output ready);
endinterface

// ----- rtl/mcbf_ram.sv -----
// ----------------------------------------------------------------------------
// mcbf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcbf_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/multi_channel_byte_fifo.sv -----
// ----------------------------------------------------------------------------
// multi_channel_byte_fifo
// Several byte ring buffers in one shared store, per-channel pointers,
// per-call accepted count with drop-after-full on writes.
// ----------------------------------------------------------------------------
//   port  dir  handshake     payload
//   cmd   in   valid/ready   mode, channel, data_in, last
//   rsp   out  valid/ready   data_out, status, accepted_count, now_empty, now_full
//
// One item per cycle while rsp is ready; each result follows in the next cycle.
// Pointer update, store write and store read all happen at the accept edge,
// so a pop right after a push to the same slot sees the new byte.
// cmd.ready = result register empty or being taken this cycle.
// Reset clears pointers, call count and drop flag; store contents are not reset.
// ----------------------------------------------------------------------------
module multi_channel_byte_fifo (
  input logic clk,
  input logic rst,
  mcbf_cmd_if.sink   cmd,
  mcbf_rsp_if.source rsp
);
  import mcbf_pkg::*;

  ptr_t    rptr [CHANNELS];
  ptr_t    wptr [CHANNELS];
  count_t  call_count;
  logic    call_stopped;

  logic    out_valid;
  status_t out_status;
  count_t  out_count;
  logic    out_empty;
  logic    out_full;
  logic    out_rd_ok;
  byte_t   ram_q;

  logic    acc;
  logic    ch_ok;
  ch_idx_t ch_idx;
  ptr_t    rp;
  ptr_t    wp;
  logic    is_empty;
  logic    is_full;
  count_t  count_inc;

  ptr_t    rp_next;
  ptr_t    wp_next;
  count_t  count_next;
  logic    stopped_next;
  status_t status_next;
  logic    wr_en;
  logic    rd_ok;
  logic    empty_next;
  logic    full_next;

  assign cmd.ready = !out_valid || rsp.ready;
  assign acc       = cmd.valid && cmd.ready;

  assign ch_ok     = {1'b0, cmd.channel} < 4'(CHANNELS);
  assign ch_idx    = cmd.channel[CH_W-1:0];
  assign rp        = rptr[ch_idx];
  assign wp        = wptr[ch_idx];
  assign is_empty  = (rp == wp);
  assign is_full   = (next_slot(wp) == rp);
  assign count_inc = (call_count == '1) ? call_count : call_count + 1'b1;

  always_comb begin
    rp_next      = rp;
    wp_next      = wp;
    count_next   = call_count;
    stopped_next = call_stopped;
    status_next  = ST_OK;
    wr_en        = 1'b0;
    rd_ok        = 1'b0;
    if (!ch_ok) begin
      status_next = ST_BADCH;
    end else begin
      unique case (cmd.mode)
        MODE_WRITE: begin
          if (call_stopped || is_full) begin
            stopped_next = 1'b1;
            status_next  = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wp_next    = next_slot(wp);
            count_next = count_inc;
          end
        end
        MODE_READ: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            rd_ok      = 1'b1;
            rp_next    = next_slot(rp);
            count_next = count_inc;
          end
        end
        MODE_CLEAR: begin
          rp_next      = '0;
          wp_next      = '0;
          count_next   = '0;
          stopped_next = 1'b0;
        end
        default: begin
          // unused mode: no effect
        end
      endcase
    end
    empty_next = ch_ok && (rp_next == wp_next);
    full_next  = ch_ok && (next_slot(wp_next) == rp_next);
  end

  // Pointer bank and call state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rptr[i] <= '0;
        wptr[i] <= '0;
      end
      call_count   <= '0;
      call_stopped <= 1'b0;
    end else if (acc) begin
      if (ch_ok) begin
        rptr[ch_idx] <= rp_next;
        wptr[ch_idx] <= wp_next;
      end
      if (cmd.last) begin
        call_count   <= '0;
        call_stopped <= 1'b0;
      end else begin
        call_count   <= count_next;
        call_stopped <= stopped_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status <= status_next;
      out_count  <= count_next;
      out_empty  <= empty_next;
      out_full   <= full_next;
      out_rd_ok  <= rd_ok;
    end
  end

  mcbf_ram #(
    .DATA_W (8),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (acc && wr_en),
    .waddr (slot_addr(ch_idx, wp)),
    .wdata (cmd.data_in),
    .re    (acc && rd_ok),
    .raddr (slot_addr(ch_idx, rp)),
    .rdata (ram_q)
  );

  assign rsp.valid          = out_valid;
  assign rsp.data_out       = out_rd_ok ? ram_q : '0;
  assign rsp.status         = out_status;
  assign rsp.accepted_count = out_count;
  assign rsp.now_empty      = out_empty;
  assign rsp.now_full       = out_full;

  a_badch_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_BADCH |-> !out_empty && !out_full)
    else $error("bad-channel result shows channel flags");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_empty && out_full))
    else $error("channel reported both empty and full");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    acc && ch_ok && cmd.mode == MODE_CLEAR |=> out_empty && out_count == '0)
    else $error("clear did not empty channel or reset count");

  a_pop_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rd_ok |-> out_count != '0 && out_status == ST_OK)
    else $error("successful pop without count");

  a_drop_sticks: assert property (@(posedge clk) disable iff (rst)
    acc && status_next == ST_FULL && !cmd.last |=> call_stopped)
    else $error("drop did not stop the call");

endmodule
